/* hw/rtl/dgn_pkg.sv */
// ----------------------------------------------------------------------------
// dgn_pkg
// Types and constants shared by the depth gradient normal estimator.
// ----------------------------------------------------------------------------
package dgn_pkg;

  localparam int DEPTH_W    = 16;
  localparam int NORMAL_W   = 16;
  localparam int POS_W      = 11;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int FOCAL_W    = 24;
  localparam int MAG_W      = 40;
  localparam int SMAG_W     = 30;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 32;
  localparam int QUO_W      = 15;
  localparam int REM_W      = 47;

  localparam logic signed [NORMAL_W-1:0] NORMAL_NEG_ONE = -16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_INVERSE_FOCAL,
    CFG_SELECT_LEFT,
    CFG_SELECT_RIGHT,
    CFG_SELECT_TOP,
    CFG_SELECT_BOTTOM
  } cfg_idx_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
  } in_beat_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic [POS_W-1:0]           pixel_column;
    logic [POS_W-1:0]           pixel_row;
    logic                       is_default;
    logic                       last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] nx;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nz;
  } normal_t;

  typedef enum logic [2:0] {
    T_IDLE, T_RD_C, T_RD_R, T_CALC, T_OUT1, T_OUT2
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_MAG, N_SHIFT, N_SUMSQ, N_SQRT, N_DIVINIT, N_DIV, N_DONE
  } norm_state_t;

endpackage

/* hw/rtl/dgn_stream_if.sv */
// ----------------------------------------------------------------------------
// dgn_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dgn_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

/* hw/rtl/dgn_ram.sv */
// ----------------------------------------------------------------------------
// dgn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dgn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dgn_norm.sv */
// ----------------------------------------------------------------------------
// dgn_norm
// Forms the gradient vector and scales it to a Q1.14 unit normal using a
// shared squarer, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module dgn_norm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dgn_pkg::DEPTH_W-1:0]  c_in,
  input  logic [dgn_pkg::DEPTH_W-1:0]  r_in,
  input  logic [dgn_pkg::DEPTH_W-1:0]  b_in,
  input  logic [dgn_pkg::FOCAL_W-1:0]  focal,
  output logic                         done,
  output dgn_pkg::normal_t             result
);
  import dgn_pkg::*;

  norm_state_t state_r, state_nxt;

  logic [DEPTH_W-1:0]  c_r, r_r, b_r;
  logic [MAG_W-1:0]    mag_r [3];
  logic [2:0]          neg_r;
  logic [SMAG_W-1:0]   m_r [3];
  logic [SUM_W-1:0]    acc_r;
  logic [1:0]          k_r;
  logic [63:0]         v_r, res_r, bit_r;
  logic [ROOT_W-1:0]   n_r;
  logic [REM_W-1:0]    rem_r;
  logic [3:0]          i_r;
  logic [QUO_W-1:0]    q_r;
  logic [NORMAL_W-1:0] comp_r [3];

  logic [MAG_W-1:0]    mmax;
  logic [3:0]          sh;
  logic [2*SMAG_W-1:0] sq;
  logic [SUM_W-1:0]    acc_sum;
  logic [63:0]         trial_sq;
  logic [REM_W-1:0]    trial_div;
  logic [QUO_W-1:0]    q_fin;

  always_comb begin
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];
    sh = '0;
    // highest set bit at or above 2^30 sets the common shift
    for (int j = SMAG_W; j < MAG_W; j++) begin
      if (mmax[j]) sh = 4'(j - SMAG_W + 1);
    end
  end

  assign sq        = m_r[k_r] * m_r[k_r];
  assign acc_sum   = acc_r + SUM_W'(sq);
  assign trial_sq  = res_r + bit_r;
  assign trial_div = REM_W'({n_r, 1'b0}) << i_r;

  always_comb begin
    q_fin = q_r;
    if (rem_r >= trial_div) q_fin[i_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done      = 1'b0;
    case (state_r)
      N_IDLE:    if (start) state_nxt = N_MAG;
      N_MAG:     state_nxt = N_SHIFT;
      N_SHIFT:   state_nxt = N_SUMSQ;
      N_SUMSQ: begin
        if (k_r == 2'd2) state_nxt = (acc_sum == '0) ? N_DONE : N_SQRT;
      end
      N_SQRT:    if (bit_r == 64'd1) state_nxt = N_DIVINIT;
      N_DIVINIT: state_nxt = N_DIV;
      N_DIV: begin
        if (i_r == '0) state_nxt = (k_r == 2'd2) ? N_DONE : N_DIVINIT;
      end
      N_DONE: begin
        done      = 1'b1;
        state_nxt = N_IDLE;
      end
      default:   state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        c_r <= c_in;
        r_r <= r_in;
        b_r <= b_in;
      end
      N_MAG: begin
        neg_r[0] <= r_r < c_r;
        neg_r[1] <= 1'b1;
        neg_r[2] <= b_r > c_r;
        mag_r[0] <= {(r_r < c_r) ? (c_r - r_r) : (r_r - c_r), 24'd0};
        mag_r[1] <= MAG_W'(c_r) * MAG_W'(focal);
        mag_r[2] <= {(b_r > c_r) ? (b_r - c_r) : (c_r - b_r), 24'd0};
      end
      N_SHIFT: begin
        for (int j = 0; j < 3; j++) m_r[j] <= SMAG_W'(mag_r[j] >> sh);
        acc_r <= '0;
        k_r   <= '0;
      end
      N_SUMSQ: begin
        acc_r <= acc_sum;
        k_r   <= k_r + 2'd1;
        v_r   <= 64'(acc_sum);
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        if (acc_sum == '0) begin
          comp_r[0] <= '0;
          comp_r[1] <= NORMAL_NEG_ONE;
          comp_r[2] <= '0;
        end
      end
      N_SQRT: begin
        if (v_r >= trial_sq) begin
          v_r   <= v_r - trial_sq;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          n_r <= (v_r >= trial_sq) ? ROOT_W'((res_r >> 1) + bit_r) : ROOT_W'(res_r >> 1);
          k_r <= '0;
        end
      end
      N_DIVINIT: begin
        rem_r <= REM_W'({m_r[k_r], 15'd0}) + REM_W'(n_r);
        i_r   <= 4'(QUO_W - 1);
        q_r   <= '0;
      end
      N_DIV: begin
        if (rem_r >= trial_div) rem_r <= rem_r - trial_div;
        q_r <= q_fin;
        i_r <= i_r - 4'd1;
        if (i_r == '0) begin
          comp_r[k_r] <= neg_r[k_r] ? (NORMAL_W'(0) - NORMAL_W'(q_fin)) : NORMAL_W'(q_fin);
          k_r <= k_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign result.nx = comp_r[0];
  assign result.ny = comp_r[1];
  assign result.nz = comp_r[2];

endmodule

/* hw/rtl/depth_gradient_normal_estimator_top.sv */
// ----------------------------------------------------------------------------
// depth_gradient_normal_estimator_top
// Surface normals from a raster depth stream using a one-row line store.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  in_ch    | in  | depth                                    | valid/ready
//  out_ch   | out | normal_x/y/z, column, row, default, last | valid/ready
//  cfg_*    | in  | index, data                              | write enable
//
//  one pixel at a time: two line store reads plus one write, then
//  a computed normal passes through the square root and divider,
//  each result then holds until taken (zero, one or two per pixel).
//  reset is synchronous; line store contents are not cleared.
//  in_ch.ready is high only while no pixel is in progress.
module depth_gradient_normal_estimator_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int DEPTH_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dgn_stream_if.sink                      in_ch,
  dgn_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [dgn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dgn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dgn_pkg::*;

  localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [DEPTH_W-1:0] DMASK =
    (DEPTH_BITS >= DEPTH_W) ? {DEPTH_W{1'b1}} : DEPTH_W'((1 << DEPTH_BITS) - 1);

  logic [11:0]        image_width_r, image_height_r;
  logic [FOCAL_W-1:0] inverse_focal_r;
  logic [POS_W-1:0]   sel_left_r, sel_right_r, sel_top_r, sel_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 12'd640;
      image_height_r  <= 12'd480;
      inverse_focal_r <= 24'd31957;
      sel_left_r      <= 11'd0;
      sel_right_r     <= 11'd2047;
      sel_top_r       <= 11'd0;
      sel_bottom_r    <= 11'd2047;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[11:0];
        CFG_INVERSE_FOCAL: inverse_focal_r <= cfg_data[FOCAL_W-1:0];
        CFG_SELECT_LEFT:   sel_left_r      <= cfg_data[POS_W-1:0];
        CFG_SELECT_RIGHT:  sel_right_r     <= cfg_data[POS_W-1:0];
        CFG_SELECT_TOP:    sel_top_r       <= cfg_data[POS_W-1:0];
        CFG_SELECT_BOTTOM: sel_bottom_r    <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  top_state_t state_r, state_nxt;

  logic [XW-1:0]      col_r;
  logic [YW-1:0]      row_r;
  logic [XW-1:0]      x_r;
  logic [POS_W-1:0]   pos_col_r, pos_row1_r, pos_row_r;
  logic [DEPTH_W-1:0] d_r, c_r;
  logic               lastcol_r, emit1_r, emit2_r;
  out_beat_t          out_r, out_nxt;

  logic [31:0]        w32, h32, x32, y32;
  logic [XW-1:0]      xc;
  logic               last_col, last_row, col_in, emit1, emit2;
  logic               in_acc, out_acc;
  logic [XW-1:0]      raddr;
  logic [DEPTH_W-1:0] rdata, r_val;
  logic               is_dflt;
  logic               norm_start, norm_done;
  normal_t            norm_res;

  always_comb begin
    w32 = (image_width_r < 12'd2) ? 32'd2 :
          ((32'(image_width_r) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(image_width_r));
    h32 = (image_height_r < 12'd2) ? 32'd2 :
          ((32'(image_height_r) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(image_height_r));
    x32 = (32'(col_r) >= MAX_WIDTH) ? 32'(MAX_WIDTH - 1) : 32'(col_r);
    y32 = 32'(row_r);
    xc  = XW'(x32);
    last_col = 32'(col_r) >= w32 - 32'd1;
    last_row = y32 >= h32 - 32'd1;
    col_in   = (x32 >= 32'(sel_left_r)) && (x32 <= 32'(sel_right_r));
    emit1    = (y32 > 0) && col_in && ((y32 - 32'd1) >= 32'(sel_top_r)) &&
               ((y32 - 32'd1) <= 32'(sel_bottom_r));
    emit2    = last_row && col_in && (y32 >= 32'(sel_top_r)) &&
               (y32 <= 32'(sel_bottom_r));
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + YW'(1);
        end else begin
          col_r <= xc + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_r        <= in_ch.data.depth & DMASK;
      x_r        <= xc;
      pos_col_r  <= POS_W'(x32);
      pos_row1_r <= POS_W'(y32 - 32'd1);
      pos_row_r  <= POS_W'(y32);
      lastcol_r  <= last_col;
      emit1_r    <= emit1;
      emit2_r    <= emit2;
    end
    if (state_r == T_RD_C) c_r <= rdata;
    out_r <= out_nxt;
  end

  assign raddr = (state_r == T_RD_C) ? x_r + XW'(1) : xc;
  assign r_val = lastcol_r ? '0 : rdata;
  assign is_dflt = lastcol_r || (c_r == '0) || (r_val == '0) || (d_r == '0);

  dgn_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (state_r == T_RD_R),
    .waddr (x_r),
    .wdata (d_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  dgn_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .c_in   (c_r),
    .r_in   (r_val),
    .b_in   (d_r),
    .focal  (inverse_focal_r),
    .done   (norm_done),
    .result (norm_res)
  );

  always_comb begin
    out_beat_t dflt1, dflt2;
    dflt1 = '{normal_x: '0, normal_y: NORMAL_NEG_ONE, normal_z: '0,
              pixel_column: pos_col_r, pixel_row: pos_row1_r,
              is_default: 1'b1, last_of_run: !emit2_r};
    dflt2 = '{normal_x: '0, normal_y: NORMAL_NEG_ONE, normal_z: '0,
              pixel_column: pos_col_r, pixel_row: pos_row_r,
              is_default: 1'b1, last_of_run: 1'b1};
    state_nxt  = state_r;
    out_nxt    = out_r;
    norm_start = 1'b0;
    case (state_r)
      T_IDLE: if (in_acc) state_nxt = T_RD_C;
      T_RD_C: state_nxt = T_RD_R;
      T_RD_R: begin
        if (emit1_r) begin
          if (is_dflt) begin
            out_nxt   = dflt1;
            state_nxt = T_OUT1;
          end else begin
            norm_start = 1'b1;
            state_nxt  = T_CALC;
          end
        end else if (emit2_r) begin
          out_nxt   = dflt2;
          state_nxt = T_OUT2;
        end else begin
          state_nxt = T_IDLE;
        end
      end
      T_CALC: begin
        if (norm_done) begin
          out_nxt            = dflt1;
          out_nxt.normal_x   = norm_res.nx;
          out_nxt.normal_y   = norm_res.ny;
          out_nxt.normal_z   = norm_res.nz;
          out_nxt.is_default = 1'b0;
          state_nxt          = T_OUT1;
        end
      end
      T_OUT1: begin
        if (out_acc) begin
          if (emit2_r) begin
            out_nxt   = dflt2;
            state_nxt = T_OUT2;
          end else begin
            state_nxt = T_IDLE;
          end
        end
      end
      T_OUT2: if (out_acc) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  assign in_ch.ready  = (state_r == T_IDLE);
  assign out_ch.valid = (state_r == T_OUT1) || (state_r == T_OUT2);
  assign out_ch.data  = out_r;

endmodule

/* hw/rtl/dgn_checker.sv */
// ----------------------------------------------------------------------------
// dgn_checker
// Port-level checks on the normal estimator, bound to the top level.
// ----------------------------------------------------------------------------
module dgn_checker (
  input logic          clk,
  input logic          rst_n,
  dgn_stream_if.sink   in_ch,
  dgn_stream_if.source out_ch
);
  import dgn_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result beat dropped or changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second pixel taken back to back");

  // the second result of a pixel follows at once
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.data.last_of_run |=> out_ch.valid)
    else $error("run broken before its last beat");

  a_default_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.is_default |->
      out_ch.data.normal_x == '0 && out_ch.data.normal_z == '0 &&
      out_ch.data.normal_y == NORMAL_NEG_ONE)
    else $error("default beat carries a wrong normal");

endmodule

bind depth_gradient_normal_estimator_top dgn_checker u_dgn_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
